// ===== sv/crbik_pkg.sv =====
// Shared types and constants for the cartridge register bank with IRQ counter
// and kanji lookup. No dependencies.
package crbik_pkg;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [3:0] REG_WRAM6    = 4'd0;
    localparam logic [3:0] REG_WRAM7    = 4'd1;
    localparam logic [3:0] REG_PRG8     = 4'd2;
    localparam logic [3:0] REG_PRGA     = 4'd3;
    localparam logic [3:0] REG_PRGC     = 4'd4;
    localparam logic [3:0] REG_CHR      = 4'd5;
    localparam logic [3:0] REG_LATCH_LO = 4'd6;
    localparam logic [3:0] REG_LATCH_HI = 4'd7;
    localparam logic [3:0] REG_ACK      = 4'd8;
    localparam logic [3:0] REG_CTRL     = 4'd9;
    localparam logic [3:0] REG_NT       = 4'd10;
    localparam logic [3:0] REG_JFLAG    = 4'd11;
    localparam logic [3:0] REG_JCOL     = 4'd12;
    localparam logic [3:0] REG_JROW     = 4'd13;

    localparam logic [11:0] OFF_KANJI_LO = 12'hC00;
    localparam logic [11:0] OFF_KANJI_HI = 12'hD00;

    localparam logic [7:0] JIS_BASE  = 8'h20;
    localparam logic [7:0] JIS_LIMIT = 8'h60;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] offset;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_claimed;
        logic       irq_asserted;
        logic [6:0] prg_page_8000;
        logic [6:0] prg_page_a000;
        logic [6:0] prg_page_c000;
        logic [5:0] ram_page_6000;
        logic [5:0] ram_page_7000;
        logic       chr_page_low;
        logic       horizontal_mirror;
        logic       exram_write_enable;
    } t_out_item;

    // glyph bank for each 256-code block of the kanji ROM
    function automatic logic [3:0] glyph_page(input logic [5:0] idx);
        logic [3:0] p;
        case (idx)
            6'd0, 6'd1:   p = 4'h0;
            6'd2, 6'd3:   p = 4'h2;
            6'd4, 6'd5:   p = 4'h1;
            6'd34, 6'd35: p = 4'hD;
            default: begin
                if (idx >= 6'd6 && idx <= 6'd17) begin
                    p = 4'(idx - 6'd2);
                end else if (idx >= 6'd18 && idx <= 6'd33) begin
                    p = 4'(idx - 6'd18);
                end else begin
                    p = 4'h0;
                end
            end
        endcase
        return p;
    endfunction

    function automatic logic [6:0] prg_page(input logic [7:0] r);
        return r[6] ? ({1'b0, r[5:0]} + 7'h10) : {3'b000, r[3:0]};
    endfunction

    function automatic logic [5:0] ram_page(input logic [7:0] r);
        return {5'b00000, r[0]} | r[7:2];
    endfunction

endpackage

// ===== sv/cartridge_register_bank_irq_kanji_top.sv =====
// Cartridge register bank, IRQ counter and kanji lookup, CPU side.
// Depends on crbik_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one bus write, bus
//   read or CPU cycle tick per transfer. Output channel (o_out_valid /
//   i_out_ready / o_out) returns one result per input transfer, in order,
//   showing read data and the bank, mirroring and IRQ state after that item.
//   Latency: a result is valid the cycle after its input transfer.
//   Throughput: one item per cycle while results are taken. All state update
//   and decode is one short combinational pass from the accepted item and the
//   register bank into the single output register.
//   Stall: while a result waits and i_out_ready is low, o_in_ready drops; when
//   the result is taken the next item is accepted in the same cycle.
//   Reset (i_rst_n low, synchronous): all 16 registers, the IRQ counter and the
//   IRQ line clear, and the output register empties. No clearing pass.
//   Reads other than at 0xC00 and 0xD00 return 0 and are not claimed.
module cartridge_register_bank_irq_kanji_top
    import crbik_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic [7:0]  r_regs [16];
    logic [7:0]  n_regs [16];
    logic [15:0] r_count, n_count;
    logic        r_irq, n_irq;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic        in_fire;
    logic [3:0]  wr_idx;
    logic [15:0] latch;
    logic [16:0] count_inc;
    logic [7:0]  jrow, jcol;
    logic [5:0]  page_idx;
    logic [3:0]  gpage;
    logic [7:0]  kanji_data;
    logic        claimed;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign wr_idx    = i_in.offset[11:8];
    assign latch     = {r_regs[REG_LATCH_HI], r_regs[REG_LATCH_LO]};
    assign count_inc = {1'b0, r_count} + 17'd1;

    // JIS row/column to glyph bank: block = row[3] + 2*col/32 + 6*row/16
    assign jrow     = r_regs[REG_JROW] - JIS_BASE;
    assign jcol     = r_regs[REG_JCOL] - JIS_BASE;
    assign page_idx = {5'b00000, jrow[3]} + {3'b000, jcol[6:5], 1'b0}
                    + {1'b0, jrow[6:4], 2'b00} + {2'b00, jrow[6:4], 1'b0};
    assign gpage    = glyph_page(page_idx);
    assign claimed  = (i_in.func == FUNC_READ)
                   && (i_in.offset == OFF_KANJI_LO || i_in.offset == OFF_KANJI_HI);

    always_comb begin
        if (jrow >= JIS_LIMIT || jcol >= JIS_LIMIT) begin
            kanji_data = 8'h00;
        end else if (i_in.offset == OFF_KANJI_LO) begin
            kanji_data = {jrow[0], jcol[4:0], r_regs[REG_JFLAG][1:0]};
        end else begin
            kanji_data = {r_regs[REG_JFLAG][2], 1'b1, gpage, jrow[2:1]};
        end
    end

    always_comb begin
        n_regs  = r_regs;
        n_count = r_count;
        n_irq   = r_irq;
        if (in_fire) begin
            unique case (i_in.func)
                FUNC_WRITE: begin
                    n_regs[wr_idx] = i_in.write_data;
                    if (wr_idx == REG_ACK) begin
                        n_regs[REG_CTRL][1] = r_regs[REG_CTRL][0];
                        n_irq = 1'b0;
                    end else if (wr_idx == REG_CTRL) begin
                        if (i_in.write_data[1]) begin
                            n_count = latch;
                        end
                        n_irq = 1'b0;
                    end
                end
                FUNC_TICK: begin
                    if (r_regs[REG_CTRL][1]) begin
                        if (count_inc[16]) begin
                            n_irq   = 1'b1;
                            n_count = latch;
                        end else begin
                            n_count = count_inc[15:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (in_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        n_out.read_data          = claimed ? kanji_data : 8'h00;
        n_out.read_claimed       = claimed;
        n_out.irq_asserted       = n_irq;
        n_out.prg_page_8000      = prg_page(n_regs[REG_PRG8]);
        n_out.prg_page_a000      = prg_page(n_regs[REG_PRGA]);
        n_out.prg_page_c000      = prg_page(n_regs[REG_PRGC]);
        n_out.ram_page_6000      = ram_page(n_regs[REG_WRAM6]);
        n_out.ram_page_7000      = ram_page(n_regs[REG_WRAM7]);
        n_out.chr_page_low       = n_regs[REG_CHR][0];
        n_out.horizontal_mirror  = n_regs[REG_NT][1];
        n_out.exram_write_enable = n_regs[REG_NT][0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_regs[i] <= 8'h00;
            end
            r_count     <= 16'h0000;
            r_irq       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_regs      <= n_regs;
            r_count     <= n_count;
            r_irq       <= n_irq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while result stalled");

    a_ack_clears_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.func == FUNC_WRITE && (wr_idx == REG_ACK || wr_idx == REG_CTRL))
        |=> (o_out_valid && !o_out.irq_asserted))
        else $error("acknowledge write did not clear IRQ");

    a_unclaimed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.read_claimed) |-> (o_out.read_data == 8'h00))
        else $error("unclaimed result carries read data");

    a_irq_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq) |-> $past(in_fire && i_in.func == FUNC_TICK))
        else $error("IRQ raised without a tick");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for cartridge_register_bank_irq_kanji_top: directed and random bus
// writes, reads and ticks, checked against a scoreboard predictor of the bank.
// Depends on crbik_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb;
    import crbik_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 700;

    // glyph bank per 256-code block of the kanji ROM
    localparam logic [3:0] GLYPH_BANK [36] = '{
        4'h0, 4'h0, 4'h2, 4'h2, 4'h1, 4'h1, 4'h4, 4'h5, 4'h6, 4'h7, 4'h8, 4'h9,
        4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF, 4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5,
        4'h6, 4'h7, 4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF, 4'hD, 4'hD
    };

    class cart_scoreboard;
        logic [7:0]  reg_bank [16];
        logic [15:0] irq_count;
        logic        irq_line;
        t_out_item   expected_q [$];
        int          errors;

        function new();
            for (int i = 0; i < 16; i++) reg_bank[i] = 8'h00;
            irq_count = 16'h0000;
            irq_line  = 1'b0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [7:0] kanji_byte(logic [11:0] off);
            logic [7:0]  row;
            logic [7:0]  col;
            int          code;
            logic [11:0] glyph;
            logic [13:0] tile;
            row = reg_bank[REG_JROW] - JIS_BASE;
            col = reg_bank[REG_JCOL] - JIS_BASE;
            if (row >= JIS_LIMIT || col >= JIS_LIMIT) return 8'h00;
            code = (col % 32) + (row % 16) * 32 + (col / 32) * 512 + (row / 16) * 1536;
            glyph = {GLYPH_BANK[(code >> 8) % 36], code[7:0]};
            tile = {glyph, 2'b00};
            if (off == OFF_KANJI_LO) return tile[7:0] | {6'b0, reg_bank[REG_JFLAG][1:0]};
            return {reg_bank[REG_JFLAG][2], 1'b1, tile[13:8]};
        endfunction

        function logic [6:0] prg_decode(logic [7:0] r);
            if (r[6]) return {1'b0, r[5:0]} + 7'h10;
            return {3'b000, r[3:0]};
        endfunction

        function void note_input(t_in_item it);
            t_out_item  exp_item;
            logic [3:0] idx;
            exp_item = '0;
            idx = it.offset[11:8];
            case (it.func)
                FUNC_WRITE: begin
                    reg_bank[idx] = it.write_data;
                    if (idx == REG_ACK) begin
                        // acknowledge bit of control is copied into enable
                        reg_bank[REG_CTRL][1] = reg_bank[REG_CTRL][0];
                        irq_line = 1'b0;
                    end else if (idx == REG_CTRL) begin
                        if (reg_bank[REG_CTRL][1])
                            irq_count = {reg_bank[REG_LATCH_HI], reg_bank[REG_LATCH_LO]};
                        irq_line = 1'b0;
                    end
                end
                FUNC_READ: begin
                    if (it.offset == OFF_KANJI_LO || it.offset == OFF_KANJI_HI) begin
                        exp_item.read_claimed = 1'b1;
                        exp_item.read_data = kanji_byte(it.offset);
                    end
                end
                FUNC_TICK: begin
                    if (reg_bank[REG_CTRL][1]) begin
                        irq_count = irq_count + 16'd1;
                        if (irq_count == 16'h0000) begin
                            irq_line = 1'b1;
                            irq_count = {reg_bank[REG_LATCH_HI], reg_bank[REG_LATCH_LO]};
                        end
                    end
                end
                default: ;
            endcase
            exp_item.irq_asserted       = irq_line;
            exp_item.prg_page_8000      = prg_decode(reg_bank[REG_PRG8]);
            exp_item.prg_page_a000      = prg_decode(reg_bank[REG_PRGA]);
            exp_item.prg_page_c000      = prg_decode(reg_bank[REG_PRGC]);
            exp_item.ram_page_6000      = {5'b0, reg_bank[REG_WRAM6][0]} | reg_bank[REG_WRAM6][7:2];
            exp_item.ram_page_7000      = {5'b0, reg_bank[REG_WRAM7][0]} | reg_bank[REG_WRAM7][7:2];
            exp_item.chr_page_low       = reg_bank[REG_CHR][0];
            exp_item.horizontal_mirror  = reg_bank[REG_NT][1];
            exp_item.exram_write_enable = reg_bank[REG_NT][0];
            expected_q.push_back(exp_item);
        endfunction

        function void compare_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
            if (exp_val !== got_val) begin
                $error("%s mismatch: expected %0h, got %0h", name, exp_val, got_val);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (expected_q.size() == 0) begin
                $error("result transfer with no pending expectation");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("read_data", e.read_data, got.read_data);
            compare_field("read_claimed", 8'(e.read_claimed), 8'(got.read_claimed));
            compare_field("irq_asserted", 8'(e.irq_asserted), 8'(got.irq_asserted));
            compare_field("prg_page_8000", 8'(e.prg_page_8000), 8'(got.prg_page_8000));
            compare_field("prg_page_a000", 8'(e.prg_page_a000), 8'(got.prg_page_a000));
            compare_field("prg_page_c000", 8'(e.prg_page_c000), 8'(got.prg_page_c000));
            compare_field("ram_page_6000", 8'(e.ram_page_6000), 8'(got.ram_page_6000));
            compare_field("ram_page_7000", 8'(e.ram_page_7000), 8'(got.ram_page_7000));
            compare_field("chr_page_low", 8'(e.chr_page_low), 8'(got.chr_page_low));
            compare_field("horizontal_mirror", 8'(e.horizontal_mirror),
                          8'(got.horizontal_mirror));
            compare_field("exram_write_enable", 8'(e.exram_write_enable),
                          8'(got.exram_write_enable));
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_item = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out;

    cart_scoreboard sb;
    logic burst = 1'b0;
    int   counted_items = 0;
    int   cycle_count = 0;

    cartridge_register_bank_irq_kanji_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input t_in_item it);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
        // ignored items do not advance the random budget
        if (it.func != FUNC_UNUSED && !(it.func == FUNC_READ &&
                it.offset != OFF_KANJI_LO && it.offset != OFF_KANJI_HI))
            counted_items++;
    endtask

    task automatic send_fields(input logic [1:0] f, input logic [11:0] off,
                               input logic [7:0] d);
        t_in_item it;
        it.func = f;
        it.offset = off;
        it.write_data = d;
        send_item(it);
    endtask

    task automatic reg_write(input logic [3:0] idx, input logic [7:0] d);
        send_fields(FUNC_WRITE, {idx, 8'($urandom)}, d);
    endtask

    task automatic bus_read(input logic [11:0] off);
        send_fields(FUNC_READ, off, 8'($urandom));
    endtask

    task automatic cpu_tick();
        send_fields(FUNC_TICK, 12'($urandom), 8'($urandom));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] jis_coord();
        if ($urandom_range(0, 7) == 0) return 8'($urandom);
        return JIS_BASE + 8'($urandom_range(0, 8'h5F));
    endfunction

    task automatic kanji_sequence();
        int n;
        reg_write(REG_JROW, jis_coord());
        reg_write(REG_JCOL, jis_coord());
        if ($urandom_range(0, 1)) reg_write(REG_JFLAG, 8'($urandom));
        n = $urandom_range(1, 3);
        repeat (n) bus_read($urandom_range(0, 1) ? OFF_KANJI_LO : OFF_KANJI_HI);
    endtask

    task automatic irq_sequence();
        int n;
        logic [7:0] ctrl;
        reg_write(REG_LATCH_LO, $urandom_range(0, 3) == 0 ? 8'($urandom)
                                                         : 8'hF0 + 8'($urandom_range(0, 15)));
        reg_write(REG_LATCH_HI, $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'hFF);
        ctrl = 8'($urandom);
        if ($urandom_range(0, 4) != 0) ctrl[1] = 1'b1;
        reg_write(REG_CTRL, ctrl);
        n = $urandom_range(1, 24);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: bus_read($urandom_range(0, 1) ? OFF_KANJI_LO : OFF_KANJI_HI);
                1: reg_write(REG_ACK, 8'($urandom));
                default: cpu_tick();
            endcase
        end
    endtask

    task automatic bank_sequence();
        logic [3:0] idx;
        case ($urandom_range(0, 6))
            0: idx = REG_WRAM6;
            1: idx = REG_WRAM7;
            2: idx = REG_PRG8;
            3: idx = REG_PRGA;
            4: idx = REG_PRGC;
            5: idx = REG_CHR;
            default: idx = REG_NT;
        endcase
        reg_write(idx, 8'($urandom));
    endtask

    task automatic noise_item();
        send_fields(2'($urandom), 12'($urandom), 8'($urandom));
    endtask

    // result side: random stall before each transfer, none in bursts
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_out);
        end
    end

    initial begin
        int next_drain;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: decode extremes, kanji range edges, unclaimed reads, IRQ wrap
        bus_read(OFF_KANJI_LO);
        reg_write(REG_PRG8, 8'h7F);
        reg_write(REG_PRGA, 8'h0F);
        reg_write(REG_PRGC, 8'hB5);
        reg_write(REG_WRAM6, 8'hFF);
        reg_write(REG_WRAM7, 8'h02);
        reg_write(REG_CHR, 8'hFF);
        reg_write(REG_NT, 8'h03);
        reg_write(REG_JROW, 8'h7F);
        reg_write(REG_JCOL, 8'h7F);
        reg_write(REG_JFLAG, 8'h07);
        bus_read(OFF_KANJI_LO);
        bus_read(OFF_KANJI_HI);
        reg_write(REG_JROW, JIS_BASE);
        reg_write(REG_JCOL, JIS_BASE + JIS_LIMIT);
        bus_read(OFF_KANJI_HI);
        send_fields(FUNC_READ, 12'hC01, 8'hFF);
        send_fields(FUNC_READ, 12'hFFF, 8'h00);
        reg_write(REG_LATCH_LO, 8'hFE);
        reg_write(REG_LATCH_HI, 8'hFF);
        reg_write(REG_CTRL, 8'h02);
        cpu_tick();
        cpu_tick();
        cpu_tick();
        reg_write(REG_ACK, 8'h00);
        cpu_tick();
        send_fields(FUNC_UNUSED, 12'hFFF, 8'hFF);
        reg_write(REG_CTRL, 8'h03);
        reg_write(REG_ACK, 8'hFF);
        reg_write(REG_NT, 8'h00);

        drain_results();
        counted_items = 0;
        next_drain = 100;
        while (counted_items < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: kanji_sequence();
                4, 5, 6:    irq_sequence();
                7:          bank_sequence();
                default:    noise_item();
            endcase
            if (counted_items >= next_drain) begin
                drain_results();
                next_drain += 150;
            end
        end
        in_valid <= 1'b0;
        burst = 1'b0;

        drain_results();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/crbik_pkg.sv
sv/cartridge_register_bank_irq_kanji_top.sv
sim/tb.sv
